### design/terminated_command_frame_parser_defines.svh
// Assertion macros used by the bound checker in tcfp_checker.sv.
`ifndef TERMINATED_COMMAND_FRAME_PARSER_DEFINES_SVH
`define TERMINATED_COMMAND_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tcfp_pkg.sv
`default_nettype none

package tcfp_pkg;

  localparam int FRAME_BYTES = 15;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  // Only the first nine stored bytes are ever parsed.
  localparam int KEEP_BYTES  = 9;

  localparam logic [7:0] TERM_BYTE = 8'hFF;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_P      = 8'h50;

  localparam int TERM_COUNT    = 3;
  localparam int START_MIN_LEN = 12;
  localparam int STOP_MIN_LEN  = 7;
  localparam int ANY_MIN_LEN   = 4;

  localparam logic signed [31:0] SETPOINT_RESET = 32'sd400;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

endpackage

`default_nettype wire

### design/tcfp_if.sv
`default_nettype none

interface tcfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcfp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic               run_flag;
  logic signed [31:0] setpoint_tenths;
  logic [3:0]         frame_length;

  modport source (output valid, output frame_kind, output run_flag,
                  output setpoint_tenths, output frame_length, input ready);
  modport sink   (input valid, input frame_kind, input run_flag,
                  input setpoint_tenths, input frame_length, output ready);
endinterface

`default_nettype wire

### design/terminated_command_frame_parser.sv
// A frame result is registered: its valid rises in the cycle after the transfer of its third 0xFF byte.
// Throughput: one byte per cycle; the output register accepts a new result in the
// same cycle that the held one is transferred, so stalls come only from the sink.
// Reset: asynchronous, active low; clears the byte count, terminator run, run flag
// and output valid, and loads a setpoint of 400 tenths. Stored frame bytes are not reset.
`default_nettype none

module terminated_command_frame_parser
  import tcfp_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  tcfp_byte_if.sink       byte_i,
  tcfp_result_if.source   result_o
);

  logic [7:0]         store_q [KEEP_BYTES];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [1:0]         term_run_q, term_run_d;
  logic               run_q, run_d;
  logic signed [31:0] target_q, target_d;

  logic               out_valid_q;
  kind_e              kind_q, kind_d;
  logic [3:0]         len_q;

  logic               in_fire;
  logic               is_term;
  logic               frame_done;
  logic [CNT_W-1:0]   len;
  logic               pfx_st;
  logic               is_start;
  logic               is_stop;

  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign in_fire      = byte_i.valid && byte_i.ready;

  assign is_term    = (byte_i.rx_byte == TERM_BYTE);
  assign frame_done = is_term && (term_run_q == 2'(TERM_COUNT - 1));
  assign len        = (count_q < CNT_W'(FRAME_BYTES)) ? count_q + 1'b1 : count_q;

  // The byte arriving now is the last terminator, so the parsed prefix is already stored.
  assign pfx_st   = (store_q[0] == CH_S) && (store_q[1] == CH_T);
  assign is_start = (len >= CNT_W'(START_MIN_LEN)) && pfx_st && (store_q[2] == CH_A)
                    && (store_q[3] == CH_R) && (store_q[4] == CH_T);
  assign is_stop  = (len >= CNT_W'(STOP_MIN_LEN)) && pfx_st && (store_q[2] == CH_O)
                    && (store_q[3] == CH_P);

  always_comb begin
    count_d    = count_q;
    term_run_d = term_run_q;
    run_d      = run_q;
    target_d   = target_q;
    kind_d     = KIND_NONE;
    if (in_fire) begin
      count_d    = len;
      term_run_d = is_term ? term_run_q + 2'd1 : 2'd0;
      if (frame_done) begin
        count_d    = '0;
        term_run_d = 2'd0;
        if (len >= CNT_W'(ANY_MIN_LEN)) begin
          if (is_start) begin
            kind_d   = KIND_START;
            run_d    = 1'b1;
            target_d = {store_q[8], store_q[7], store_q[6], store_q[5]};
          end else if (is_stop) begin
            kind_d = KIND_STOP;
            run_d  = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      term_run_q  <= 2'd0;
      run_q       <= 1'b0;
      target_q    <= SETPOINT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      term_run_q <= term_run_d;
      run_q      <= run_d;
      target_q   <= target_d;
      if (in_fire && frame_done) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KEEP_BYTES; i++) begin
      if (in_fire && (count_q == CNT_W'(i))) begin
        store_q[i] <= byte_i.rx_byte;
      end
    end
    if (in_fire && frame_done) begin
      kind_q <= kind_d;
      len_q  <= len[3:0];
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.frame_kind      = kind_q;
  assign result_o.run_flag        = run_q;
  assign result_o.setpoint_tenths = target_q;
  assign result_o.frame_length    = len_q;

endmodule

`default_nettype wire

### design/tcfp_checker.sv
`default_nettype none
`include "terminated_command_frame_parser_defines.svh"

module tcfp_checker
  import tcfp_pkg::*;
(
  input wire               clk_i,
  input wire               rst_ni,
  input wire               out_valid_i,
  input wire               out_ready_i,
  input wire [1:0]         frame_kind_i,
  input wire               run_flag_i,
  input wire signed [31:0] setpoint_tenths_i,
  input wire [3:0]         frame_length_i
);

  `TCFP_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(frame_kind_i) && $stable(setpoint_tenths_i) && $stable(frame_length_i), "stalled result changed")
  `TCFP_ASSERT_SAME(a_start_run, clk_i, rst_ni, out_valid_i && (frame_kind_i == KIND_START), run_flag_i && (frame_length_i >= 4'(START_MIN_LEN)), "start result without run flag or too short")
  `TCFP_ASSERT_SAME(a_stop_run, clk_i, rst_ni, out_valid_i && (frame_kind_i == KIND_STOP), !run_flag_i && (frame_length_i >= 4'(STOP_MIN_LEN)), "stop result with run flag or too short")
  `TCFP_ASSERT_SAME(a_min_len, clk_i, rst_ni, out_valid_i, frame_length_i >= 4'(TERM_COUNT), "frame shorter than its terminators")

endmodule

bind terminated_command_frame_parser tcfp_checker u_tcfp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (result_o.valid),
  .out_ready_i       (result_o.ready),
  .frame_kind_i      (result_o.frame_kind),
  .run_flag_i        (result_o.run_flag),
  .setpoint_tenths_i (result_o.setpoint_tenths),
  .frame_length_i    (result_o.frame_length)
);

`default_nettype wire

### verif/terminated_command_frame_parser_checker.sv
`timescale 1ns / 1ps

module terminated_command_frame_parser_checker
  import tcfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic               byte_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               result_valid_i,
  input  logic               result_ready_i,
  input  logic [1:0]         frame_kind_i,
  input  logic               run_flag_i,
  input  logic signed [31:0] setpoint_tenths_i,
  input  logic [3:0]         frame_length_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_results_o
);

  typedef struct packed {
    kind_e              kind;
    logic               run;
    logic signed [31:0] setpoint;
    logic [3:0]         length;
  } frame_result_t;

  logic [7:0]         frame_mem [FRAME_BYTES];
  int unsigned        stored_count;
  int unsigned        ff_run;
  logic               run_on;
  logic signed [31:0] target_sp;
  frame_result_t      due_results [$];
  int unsigned        mismatches;

  task automatic note_mismatch(input string field, input longint want, input longint got);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
    mismatches++;
  endtask

  // Stores the byte, tracks the 0xFF run and queues the frame result when
  // the third 0xFF in a row arrives.
  task automatic absorb_byte(input logic [7:0] b);
    frame_result_t res;
    logic          is_start;
    logic          is_stop;
    if (stored_count < FRAME_BYTES) begin
      frame_mem[stored_count] = b;
      stored_count++;
    end
    if (b != TERM_BYTE) begin
      ff_run = 0;
    end else begin
      ff_run++;
      if (ff_run == TERM_COUNT) begin
        // The length tests come first, so only bytes of this frame are read.
        is_start = stored_count >= START_MIN_LEN && frame_mem[0] == CH_S &&
                   frame_mem[1] == CH_T && frame_mem[2] == CH_A &&
                   frame_mem[3] == CH_R && frame_mem[4] == CH_T;
        is_stop  = stored_count >= STOP_MIN_LEN && frame_mem[0] == CH_S &&
                   frame_mem[1] == CH_T && frame_mem[2] == CH_O &&
                   frame_mem[3] == CH_P;
        res.kind = KIND_NONE;
        if (is_start) begin
          target_sp = {frame_mem[8], frame_mem[7], frame_mem[6], frame_mem[5]};
          run_on    = 1'b1;
          res.kind  = KIND_START;
        end else if (is_stop) begin
          run_on   = 1'b0;
          res.kind = KIND_STOP;
        end
        res.run      = run_on;
        res.setpoint = target_sp;
        res.length   = stored_count[3:0];
        due_results.push_back(res);
        stored_count = 0;
        ff_run       = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    frame_result_t want;
    if (!rst_ni) begin
      stored_count = 0;
      ff_run       = 0;
      run_on       = 1'b0;
      target_sp    = SETPOINT_RESET;
      mismatches   = 0;
      due_results.delete();
      mismatch_count_o  <= 0;
      pending_results_o <= 0;
    end else begin
      // A result transfer always belongs to an earlier byte, so it is
      // checked before the byte of this edge is absorbed.
      if (result_valid_i && result_ready_i) begin
        if (due_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with none expected, kind %0d, length %0d",
                     $time, frame_kind_i, frame_length_i);
          end
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (frame_kind_i !== want.kind) begin
            note_mismatch("frame_kind", want.kind, frame_kind_i);
          end
          if (run_flag_i !== want.run) begin
            note_mismatch("run_flag", want.run, run_flag_i);
          end
          if (setpoint_tenths_i !== want.setpoint) begin
            note_mismatch("setpoint_tenths", want.setpoint, setpoint_tenths_i);
          end
          if (frame_length_i !== want.length) begin
            note_mismatch("frame_length", want.length, frame_length_i);
          end
        end
      end
      if (byte_valid_i && byte_ready_i) begin
        absorb_byte(rx_byte_i);
      end
      mismatch_count_o  <= mismatches;
      pending_results_o <= due_results.size();
    end
  end

endmodule

### verif/terminated_command_frame_parser_tb.sv
`timescale 1ns / 1ps

module terminated_command_frame_parser_tb;
  import tcfp_pkg::*;

  localparam int ITEMS_PER_PHASE = 450;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 4;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcfp_byte_if   byte_if ();
  tcfp_result_if result_if ();

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned src_idle_pct  = 34;
  int unsigned sink_idle_pct = 73;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned sent_bytes    = 0;
  logic [7:0]  frame_bytes [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  terminated_command_frame_parser i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  terminated_command_frame_parser_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .byte_valid_i      (byte_if.valid),
    .byte_ready_i      (byte_if.ready),
    .rx_byte_i         (byte_if.rx_byte),
    .result_valid_i    (result_if.valid),
    .result_ready_i    (result_if.ready),
    .frame_kind_i      (result_if.frame_kind),
    .run_flag_i        (result_if.run_flag),
    .setpoint_tenths_i (result_if.setpoint_tenths),
    .frame_length_i    (result_if.frame_length),
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results)
  );

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Valid is left high after a transfer; the next byte either replaces the
  // payload or an idle cycle lowers it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // The checker's pending count is registered, so it lags the last transfer.
  task automatic drain();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic build_random_frame();
    int unsigned pick;
    int unsigned pad;
    int unsigned cut;
    int unsigned pos;
    logic        is_start;
    frame_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 90) begin
      is_start = pick < 35 || (pick >= 60 && pick < 68) || pick >= 75;
      if (is_start) begin
        frame_bytes = '{CH_S, CH_T, CH_A, CH_R, CH_T};
        repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
        pad = (pick >= 75) ? $urandom_range(8, 14) : $urandom_range(0, 5);
      end else begin
        frame_bytes = '{CH_S, CH_T, CH_O, CH_P};
        pad = $urandom_range(0, 11);
      end
      repeat (pad) frame_bytes.push_back(8'($urandom_range(254)));
      if (pick >= 60 && pick < 75) begin
        pos = $urandom_range(is_start ? 4 : 3);
        frame_bytes[pos] = 8'($urandom_range(254));
      end
      // Now and then a command is cut short, which may leave it below its minimum length.
      if ($urandom_range(5) == 0) begin
        cut = $urandom_range(frame_bytes.size());
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      repeat (TERM_COUNT) frame_bytes.push_back(TERM_BYTE);
    end else begin
      // Noise rich in 0xFF, which breaks and restarts terminator runs.
      repeat ($urandom_range(1, 20)) begin
        frame_bytes.push_back(($urandom_range(9) < 4) ? TERM_BYTE : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                           input bit long_hold);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent_bytes    = 0;
    if (long_hold) hold_req++;
    while (sent_bytes < ITEMS_PER_PHASE) begin
      build_random_frame();
      send_frame();
    end
    drain();
  endtask

  initial begin
    rst_ni          <= 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.rx_byte <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Start with a setpoint that has the sign bit set and two 0xFF bytes,
    // then stop, then a frame made only of terminators.
    frame_bytes = '{CH_S, CH_T, CH_A, CH_R, CH_T, 8'h00, 8'hFF, 8'hFF, 8'h80,
                    TERM_BYTE, TERM_BYTE, TERM_BYTE};
    send_frame();
    frame_bytes = '{CH_S, CH_T, CH_O, CH_P, TERM_BYTE, TERM_BYTE, TERM_BYTE};
    send_frame();
    frame_bytes = '{TERM_BYTE, TERM_BYTE, TERM_BYTE};
    send_frame();
    drain();

    run_phase(34, 73, 1'b1);
    run_phase(73, 34, 1'b0);
    run_phase(0, 0, 1'b1);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
